// ----- rtl/sha1_pkg.sv -----
package sha1_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned DigestWords = 5;
  localparam int unsigned BlockWords = 16;

  localparam logic [31:0] HashInit [DigestWords] = '{
    32'h6745_2301, 32'hefcd_ab89, 32'h98ba_dcfe, 32'h1032_5476, 32'hc3d2_e1f0
  };

  localparam logic [31:0] RoundConst [4] = '{
    32'h5a82_7999, 32'h6ed9_eba1, 32'h8f1b_bcdc, 32'hca62_c1d6
  };

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [6:0] LastRound = 7'd79;
  localparam logic [3:0] LenHiPos = 4'd14;
  localparam logic [3:0] LastPos = 4'd15;
  localparam logic [2:0] LastDigestIdx = 3'd4;

  typedef enum logic [1:0] {
    GrpChoose = 2'd0,
    GrpParity1 = 2'd1,
    GrpMajority = 2'd2,
    GrpParity2 = 2'd3
  } sha1_group_e;

  typedef enum logic [2:0] {
    StFill,
    StMark,
    StZero,
    StLenHi,
    StLenLo,
    StRound,
    StAdd,
    StOut
  } sha1_state_e;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic        mark;
    logic [63:0] length;
  } sha1_entry_t;

  function automatic logic [31:0] mix_fn(sha1_group_e grp, logic [31:0] b,
                                         logic [31:0] c, logic [31:0] d);
    logic [31:0] res;
    case (grp)
      GrpChoose:   res = (b & c) | (~b & d);
      GrpMajority: res = (b & c) | (b & d) | (c & d);
      default:     res = b ^ c ^ d;
    endcase
    return res;
  endfunction

endpackage

// ----- rtl/sha1_front.sv -----
module sha1_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [31:0]           message_word_i,
  input  logic [2:0]            valid_bytes_i,
  input  logic                  last_item_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output sha1_pkg::sha1_entry_t q_entry_o
);

  logic [63:0] bit_len_q, bit_len_d;
  logic [63:0] len_sum;
  logic [3:0]  add_bits;
  logic        accept;

  assign accept = push_i & ~q_full_i;
  assign q_push_o = accept;

  always_comb begin
    q_entry_o.word = message_word_i;
    q_entry_o.last = last_item_i;
    q_entry_o.mark = 1'b0;
    add_bits = 4'd0;
    if (last_item_i) begin
      case (valid_bytes_i)
        3'd0: begin
          q_entry_o.word = {sha1_pkg::PadMark, 24'h0};
          add_bits = 4'd0;
        end
        3'd1: begin
          q_entry_o.word = {message_word_i[31:24], sha1_pkg::PadMark, 16'h0};
          add_bits = 4'd1;
        end
        3'd2: begin
          q_entry_o.word = {message_word_i[31:16], sha1_pkg::PadMark, 8'h0};
          add_bits = 4'd2;
        end
        3'd3: begin
          q_entry_o.word = {message_word_i[31:8], sha1_pkg::PadMark};
          add_bits = 4'd3;
        end
        default: begin
          q_entry_o.mark = 1'b1;
          add_bits = 4'd4;
        end
      endcase
    end else begin
      add_bits = 4'd4;
    end
    len_sum = bit_len_q + {57'h0, add_bits, 3'b000};
    q_entry_o.length = len_sum;
    bit_len_d = bit_len_q;
    if (accept) begin
      bit_len_d = last_item_i ? 64'h0 : len_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_len_q <= 64'h0;
    end else begin
      bit_len_q <= bit_len_d;
    end
  end

endmodule

// ----- rtl/sha1_queue.sv -----
module sha1_queue #(
  parameter int unsigned Depth = sha1_pkg::QueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  sha1_pkg::sha1_entry_t entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output sha1_pkg::sha1_entry_t entry_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  sha1_pkg::sha1_entry_t slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign entry_o = slots_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ----- rtl/sha1_core.sv -----
module sha1_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  input  sha1_pkg::sha1_entry_t q_entry_i,
  output logic                  q_pop_o,
  output logic                  empty,
  input  logic                  pop,
  output logic [31:0]           digest_word_o,
  output logic [2:0]            word_index_o,
  output logic                  last_word_o
);

  localparam int unsigned NumWords = sha1_pkg::DigestWords;
  localparam int unsigned WinDepth = sha1_pkg::BlockWords;

  sha1_pkg::sha1_state_e state_q, state_d, resume_q, resume_d, after_wr;
  sha1_pkg::sha1_group_e grp;

  logic [31:0] win_q [WinDepth];
  logic [31:0] wv_q [NumWords];
  logic [31:0] wv_d [NumWords];
  logic [31:0] chain_q [NumWords];
  logic [31:0] chain_d [NumWords];
  logic [31:0] obuf_q [NumWords];
  logic [31:0] obuf_d [NumWords];
  logic [3:0]  pos_q, pos_d, pos_next;
  logic [6:0]  round_q, round_d;
  logic [63:0] len_q, len_d;
  logic [2:0]  out_rem_q, out_rem_d, out_idx_q, out_idx_d;
  logic        wr_en, win_shift;
  logic [31:0] wr_word, win_in, sched_word, round_sum;

  assign empty         = (out_rem_q == 3'd0);
  assign digest_word_o = obuf_q[0];
  assign word_index_o  = out_idx_q;
  assign last_word_o   = (out_idx_q == sha1_pkg::LastDigestIdx);
  assign pos_next      = pos_q + 4'd1;

  always_comb begin
    if (round_q < 7'd20) begin
      grp = sha1_pkg::GrpChoose;
    end else if (round_q < 7'd40) begin
      grp = sha1_pkg::GrpParity1;
    end else if (round_q < 7'd60) begin
      grp = sha1_pkg::GrpMajority;
    end else begin
      grp = sha1_pkg::GrpParity2;
    end
    sched_word = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
    round_sum = {wv_q[0][26:0], wv_q[0][31:27]}
              + sha1_pkg::mix_fn(grp, wv_q[1], wv_q[2], wv_q[3])
              + wv_q[4] + win_q[0] + sha1_pkg::RoundConst[grp];
  end

  always_comb begin
    state_d   = state_q;
    resume_d  = resume_q;
    pos_d     = pos_q;
    round_d   = round_q;
    len_d     = len_q;
    out_rem_d = out_rem_q;
    out_idx_d = out_idx_q;
    wv_d      = wv_q;
    chain_d   = chain_q;
    obuf_d    = obuf_q;
    q_pop_o   = 1'b0;
    wr_en     = 1'b0;
    wr_word   = 32'h0;
    win_shift = 1'b0;
    win_in    = 32'h0;
    after_wr  = state_q;

    if (pop && !empty) begin
      for (int i = 0; i < NumWords - 1; i++) begin
        obuf_d[i] = obuf_q[i+1];
      end
      out_rem_d = out_rem_q - 3'd1;
      out_idx_d = out_idx_q + 3'd1;
    end

    case (state_q)
      sha1_pkg::StFill: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          wr_en   = 1'b1;
          wr_word = q_entry_i.word;
          if (q_entry_i.last) begin
            len_d = q_entry_i.length;
            if (q_entry_i.mark) begin
              after_wr = sha1_pkg::StMark;
            end else if (pos_next == sha1_pkg::LenHiPos) begin
              after_wr = sha1_pkg::StLenHi;
            end else begin
              after_wr = sha1_pkg::StZero;
            end
          end else begin
            after_wr = sha1_pkg::StFill;
          end
        end
      end
      sha1_pkg::StMark, sha1_pkg::StZero: begin
        wr_en   = 1'b1;
        wr_word = (state_q == sha1_pkg::StMark) ? {sha1_pkg::PadMark, 24'h0} : 32'h0;
        after_wr = (pos_next == sha1_pkg::LenHiPos) ? sha1_pkg::StLenHi : sha1_pkg::StZero;
      end
      sha1_pkg::StLenHi: begin
        wr_en    = 1'b1;
        wr_word  = len_q[63:32];
        after_wr = sha1_pkg::StLenLo;
      end
      sha1_pkg::StLenLo: begin
        wr_en    = 1'b1;
        wr_word  = len_q[31:0];
        after_wr = sha1_pkg::StOut;
      end
      sha1_pkg::StRound: begin
        win_shift = 1'b1;
        win_in    = {sched_word[30:0], sched_word[31]};
        wv_d[0]   = round_sum;
        wv_d[1]   = wv_q[0];
        wv_d[2]   = {wv_q[1][1:0], wv_q[1][31:2]};
        wv_d[3]   = wv_q[2];
        wv_d[4]   = wv_q[3];
        round_d   = round_q + 7'd1;
        if (round_q == sha1_pkg::LastRound) begin
          round_d = 7'd0;
          state_d = sha1_pkg::StAdd;
        end
      end
      sha1_pkg::StAdd: begin
        for (int i = 0; i < NumWords; i++) begin
          chain_d[i] = chain_q[i] + wv_q[i];
        end
        state_d = resume_q;
      end
      sha1_pkg::StOut: begin
        if (empty) begin
          obuf_d    = chain_q;
          out_rem_d = 3'(NumWords);
          out_idx_d = 3'd0;
          chain_d   = sha1_pkg::HashInit;
          state_d   = sha1_pkg::StFill;
        end
      end
      default: begin
        state_d = sha1_pkg::StFill;
      end
    endcase

    if (wr_en) begin
      win_shift = 1'b1;
      win_in    = wr_word;
      pos_d     = pos_next;
      if (pos_q == sha1_pkg::LastPos) begin
        state_d  = sha1_pkg::StRound;
        resume_d = after_wr;
        round_d  = 7'd0;
        wv_d     = chain_q;
      end else begin
        state_d = after_wr;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sha1_pkg::StFill;
      resume_q  <= sha1_pkg::StFill;
      pos_q     <= 4'd0;
      round_q   <= 7'd0;
      out_rem_q <= 3'd0;
      out_idx_q <= 3'd0;
      chain_q   <= sha1_pkg::HashInit;
      wv_q      <= '{default: 32'h0};
    end else begin
      state_q   <= state_d;
      resume_q  <= resume_d;
      pos_q     <= pos_d;
      round_q   <= round_d;
      out_rem_q <= out_rem_d;
      out_idx_q <= out_idx_d;
      chain_q   <= chain_d;
      wv_q      <= wv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    obuf_q <= obuf_d;
    if (win_shift) begin
      for (int i = 0; i < WinDepth - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WinDepth-1] <= win_in;
    end
  end

endmodule

// ----- rtl/sha1_hash_engine.sv -----
// SHA-1 engine taking big-endian message words with a byte count and a last flag; after the
// last word it delivers the five digest words, H0 first, and starts a fresh message. A front
// stage counts the message length and pads the final word, and a short queue hands words to
// the compression core, which writes one word a cycle, while the queue is not empty, into its
// sixteen-word schedule window and, once a block is full, runs the 80 rounds on a single round
// unit at one round a cycle followed by a step (StAdd) that updates the chaining value. The
// core takes no new words while it compresses a block. The last word adds the padding and
// length words at one a cycle, a second compression when the tail does not fit, and a step
// (StOut) that moves the digest into the output buffer once that is empty; the next message
// may enter the queue meanwhile, and the five digest transfers run independently of the core.
module sha1_hash_engine #(
  parameter int unsigned QueueDepth = sha1_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] message_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        last_item_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  sha1_pkg::sha1_entry_t front_entry, core_entry;
  logic front_push, q_empty, q_pop;

  sha1_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .message_word_i (message_word_i),
    .valid_bytes_i  (valid_bytes_i),
    .last_item_i    (last_item_i),
    .q_full_i       (full),
    .q_push_o       (front_push),
    .q_entry_o      (front_entry)
  );

  sha1_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .entry_i (front_entry),
    .full_o  (full),
    .pop_i   (q_pop),
    .entry_o (core_entry),
    .empty_o (q_empty)
  );

  sha1_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_entry_i     (core_entry),
    .q_pop_o       (q_pop),
    .empty         (empty),
    .pop           (pop),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

endmodule

// ----- dv/sha1_hash_engine_tb.sv -----
`timescale 1ns / 100ps

module sha1_hash_engine_tb;

  localparam int TotalItems = 160;
  localparam int CalmItems = 30;
  localparam int LongHold = 400;

  typedef struct packed {
    logic [31:0]  word;
    logic [2:0]   nbytes;
    logic         last;
    logic [4:0]   reps;
    logic         known;
    logic [159:0] digest;
  } stim_row_t;

  typedef struct {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_out_t;

  localparam int NumRows = 13;
  localparam stim_row_t StimTab [NumRows] = '{
    '{32'h0000_0000, 3'd0, 1'b1, 5'd1, 1'b1,
      160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709},
    '{32'h6162_6300, 3'd3, 1'b1, 5'd1, 1'b1,
      160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d},
    '{32'hffff_ffff, 3'd1, 1'b1, 5'd1, 1'b0, 160'h0},
    '{32'hffff_ffff, 3'd4, 1'b1, 5'd1, 1'b0, 160'h0},
    '{32'h0000_0000, 3'd4, 1'b1, 5'd1, 1'b0, 160'h0},
    '{32'h1234_5678, 3'd5, 1'b1, 5'd1, 1'b0, 160'h0},
    '{32'h9abc_def0, 3'd6, 1'b1, 5'd1, 1'b0, 160'h0},
    '{32'h0f0f_0f0f, 3'd7, 1'b1, 5'd1, 1'b0, 160'h0},
    '{32'hffff_ffff, 3'd0, 1'b0, 5'd1, 1'b0, 160'h0},
    '{32'h0000_0000, 3'd3, 1'b0, 5'd1, 1'b0, 160'h0},
    '{32'ha5a5_a5a5, 3'd2, 1'b1, 5'd1, 1'b0, 160'h0},
    '{32'hdead_beef, 3'd4, 1'b0, 5'd13, 1'b0, 160'h0},
    '{32'hcafe_f00d, 3'd4, 1'b1, 5'd1, 1'b0, 160'h0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [31:0] message_word_i;
  logic [2:0]  valid_bytes_i;
  logic        last_item_i;
  logic        empty;
  logic        pop;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  logic [31:0] hash_chain [sha1_pkg::DigestWords];
  logic [31:0] sched_win [sha1_pkg::BlockWords];
  int          fill_pos;
  logic [63:0] msg_bits;

  digest_out_t digest_q [$];
  digest_out_t want;
  int          mismatch_cnt = 0;
  int          items_sent = 0;
  bit          calm = 1'b0;
  bit          long_hold_req = 1'b0;
  bit          long_hold_done = 1'b0;
  int          hold_left = 0;

  sha1_hash_engine DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .message_word_i (message_word_i),
    .valid_bytes_i  (valid_bytes_i),
    .last_item_i    (last_item_i),
    .empty          (empty),
    .pop            (pop),
    .digest_word_o  (digest_word_o),
    .word_index_o   (word_index_o),
    .last_word_o    (last_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] rotl(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  task automatic reset_chain();
    for (int k = 0; k < sha1_pkg::DigestWords; k++) begin
      hash_chain[k] = sha1_pkg::HashInit[k];
    end
    fill_pos = 0;
    msg_bits = '0;
  endtask

  task automatic sha1_compress();
    logic [31:0] a, b, c, d, e, f, t;
    sha1_pkg::sha1_group_e grp;
    a = hash_chain[0];
    b = hash_chain[1];
    c = hash_chain[2];
    d = hash_chain[3];
    e = hash_chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16) begin
        sched_win[r % 16] = rotl(sched_win[(r + 13) % 16] ^ sched_win[(r + 8) % 16]
                                 ^ sched_win[(r + 2) % 16] ^ sched_win[r % 16], 1);
      end
      grp = sha1_pkg::sha1_group_e'(r / 20);
      case (grp)
        sha1_pkg::GrpChoose:   f = (b & c) | (~b & d);
        sha1_pkg::GrpMajority: f = (b & c) | (b & d) | (c & d);
        default:               f = b ^ c ^ d;
      endcase
      t = rotl(a, 5) + f + e + sched_win[r % 16] + sha1_pkg::RoundConst[r / 20];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    hash_chain[0] += a;
    hash_chain[1] += b;
    hash_chain[2] += c;
    hash_chain[3] += d;
    hash_chain[4] += e;
  endtask

  task automatic load_word(logic [31:0] w);
    sched_win[fill_pos] = w;
    fill_pos++;
    if (fill_pos == sha1_pkg::BlockWords) begin
      fill_pos = 0;
      sha1_compress();
    end
  endtask

  task automatic sha1_absorb(logic [31:0] word, logic [2:0] nbytes, logic last);
    int n;
    logic [31:0] keep;
    digest_out_t d;
    if (!last) begin
      msg_bits += 64'd32;
      load_word(word);
      return;
    end
    n = (nbytes > 3'd4) ? 4 : int'(nbytes);
    msg_bits += 64'(n * 8);
    if (n == 4) begin
      load_word(word);
      load_word({sha1_pkg::PadMark, 24'h0});
    end else begin
      keep = (n == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * n));
      load_word((word & keep) | (32'(sha1_pkg::PadMark) << (24 - 8 * n)));
    end
    while (fill_pos != int'(sha1_pkg::LenHiPos)) begin
      load_word(32'h0);
    end
    load_word(msg_bits[63:32]);
    load_word(msg_bits[31:0]);
    for (int k = 0; k < sha1_pkg::DigestWords; k++) begin
      d.digest_word = hash_chain[k];
      d.word_index = 3'(k);
      d.last_word = (3'(k) == sha1_pkg::LastDigestIdx);
      digest_q.push_back(d);
    end
    reset_chain();
  endtask

  task automatic send_item(logic [31:0] word, logic [2:0] nbytes, logic last);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push <= 1'b1;
    message_word_i <= word;
    valid_bytes_i <= nbytes;
    last_item_i <= last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sha1_absorb(word, nbytes, last);
    items_sent++;
    if (items_sent >= TotalItems - CalmItems) calm = 1'b1;
  endtask

  initial begin
    int msg_len;
    rst_ni = 1'b0;
    push = 1'b0;
    message_word_i = '0;
    valid_bytes_i = '0;
    last_item_i = 1'b0;
    reset_chain();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NumRows; i++) begin
      for (int r = 0; r < StimTab[i].reps; r++) begin
        send_item(StimTab[i].word, StimTab[i].nbytes, StimTab[i].last);
      end
      if (StimTab[i].known) begin
        for (int k = 0; k < sha1_pkg::DigestWords; k++) begin
          digest_q[digest_q.size() - sha1_pkg::DigestWords + k].digest_word =
            StimTab[i].digest[159 - 32 * k -: 32];
        end
      end
    end

    long_hold_req = 1'b1;
    while (items_sent < TotalItems) begin
      msg_len = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 34) : $urandom_range(0, 15);
      for (int w = 0; w < msg_len; w++) begin
        send_item($urandom, 3'($urandom_range(0, 7)), 1'b0);
      end
      send_item($urandom, 3'($urandom_range(0, 7)), 1'b1);
    end
    @(negedge clk_i);
    push <= 1'b0;

    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (digest_q.size() != 0) begin
      $error("%0d digest words never arrived", digest_q.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // The long hold-off lets the sender fill the input queue until it stalls.
  initial begin
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (long_hold_req && !long_hold_done) begin
        pop <= 1'b0;
        hold_left = LongHold - 1;
        long_hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        hold_left = $urandom_range(1, 12) - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (digest_q.size() == 0) begin
        $error("unexpected digest word %h at index %0d", digest_word_o, word_index_o);
        mismatch_cnt++;
      end else begin
        want = digest_q.pop_front();
        if (digest_word_o !== want.digest_word) begin
          $error("digest_word: expected %h, actual %h", want.digest_word, digest_word_o);
          mismatch_cnt++;
        end
        if (word_index_o !== want.word_index) begin
          $error("word_index: expected %0d, actual %0d", want.word_index, word_index_o);
          mismatch_cnt++;
        end
        if (last_word_o !== want.last_word) begin
          $error("last_word: expected %b, actual %b", want.last_word, last_word_o);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
